// ----- sv/bdpc_pkg.sv -----
package bdpc_pkg;

	localparam int CFG_W = 16;
	localparam int EV_W  = 2;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	// Press classification codes
	localparam logic [EV_W-1:0] EV_NONE  = 2'd0;
	localparam logic [EV_W-1:0] EV_SHORT = 2'd1;
	localparam logic [EV_W-1:0] EV_LONG  = 2'd2;

	// Register index (byte address bit 2)
	localparam logic REG_DEBOUNCE   = 1'b0;
	localparam logic REG_LONG_PRESS = 1'b1;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd20;
	localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd800;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_ms;
		logic [CFG_W-1:0] long_press_ms;
	} cfg_t;

endpackage

// ----- sv/bdpc_if.sv -----
interface bdpc_poll_if #(
	parameter int TIME_BITS = 32
);
	logic                 valid;
	logic                 ready;
	logic                 button_released;
	logic [TIME_BITS-1:0] time_ms;

	modport source (output valid, output button_released, output time_ms, input ready);
	modport sink   (input valid, input button_released, input time_ms, output ready);
endinterface

interface bdpc_event_if;
	logic                       valid;
	logic                       ready;
	logic [bdpc_pkg::EV_W-1:0]  press_event;

	modport source (output valid, output press_event, input ready);
	modport sink   (input valid, input press_event, output ready);
endinterface

// ----- sv/bdpc_apb_regs.sv -----
module bdpc_apb_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [bdpc_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [bdpc_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [bdpc_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	output bdpc_pkg::cfg_t                   cfg
);
	import bdpc_pkg::*;

	logic [CFG_W-1:0] debounce_q;
	logic [CFG_W-1:0] long_press_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEBOUNCE_RST;
			long_press_q <= LONG_PRESS_RST;
		end else if (wr_en) begin
			case (paddr[2])
				REG_DEBOUNCE:   debounce_q   <= pwdata[CFG_W-1:0];
				REG_LONG_PRESS: long_press_q <= pwdata[CFG_W-1:0];
				default:        debounce_q   <= debounce_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_DEBOUNCE:   prdata = {{(APB_DATA_W-CFG_W){1'b0}}, debounce_q};
			REG_LONG_PRESS: prdata = {{(APB_DATA_W-CFG_W){1'b0}}, long_press_q};
			default:        prdata = '0;
		endcase
	end

	assign cfg.debounce_ms   = debounce_q;
	assign cfg.long_press_ms = long_press_q;

endmodule

// ----- sv/bdpc_classify.sv -----
module bdpc_classify #(
	parameter int TIME_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic                        button_released,
	input  logic [TIME_BITS-1:0]        time_ms,
	input  bdpc_pkg::cfg_t              cfg,
	output logic [bdpc_pkg::EV_W-1:0]   press_event
);
	import bdpc_pkg::*;

	logic                 stable_q;
	logic                 armed_q;
	logic                 long_fired_q;
	logic                 pending_q;
	logic [TIME_BITS-1:0] edge_time_q;
	logic [TIME_BITS-1:0] press_time_q;

	logic [TIME_BITS-1:0] edge_ref;
	logic [TIME_BITS-1:0] edge_age;
	logic [TIME_BITS-1:0] press_age;
	logic                 changed;
	logic                 settle;
	logic                 long_hit;

	// A fresh change starts timing at this poll, so its age is zero
	assign edge_ref  = pending_q ? edge_time_q : time_ms;
	assign edge_age  = time_ms - edge_ref;
	assign press_age = time_ms - press_time_q;
	assign changed   = button_released != stable_q;
	assign settle    = changed &&
		(edge_age >= {{(TIME_BITS-CFG_W){1'b0}}, cfg.debounce_ms});
	assign long_hit  = !changed && armed_q && !long_fired_q && !stable_q &&
		(press_age >= {{(TIME_BITS-CFG_W){1'b0}}, cfg.long_press_ms});

	always_comb begin
		press_event = EV_NONE;
		if (settle && button_released && armed_q && !long_fired_q) begin
			press_event = EV_SHORT;
		end else if (long_hit) begin
			press_event = EV_LONG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q     <= 1'b1;
			armed_q      <= 1'b0;
			long_fired_q <= 1'b0;
			pending_q    <= 1'b0;
			edge_time_q  <= '0;
			press_time_q <= '0;
		end else if (step) begin
			if (changed) begin
				if (!pending_q) begin
					edge_time_q <= time_ms;
				end
				if (settle) begin
					pending_q <= 1'b0;
					stable_q  <= button_released;
					if (!button_released) begin
						armed_q      <= 1'b1;
						long_fired_q <= 1'b0;
						press_time_q <= time_ms;
					end else begin
						armed_q <= 1'b0;
					end
				end else begin
					pending_q <= 1'b1;
				end
			end else begin
				pending_q <= 1'b0;
				if (long_hit) begin
					long_fired_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ----- sv/button_debounce_press_classifier.sv -----
// Channel  Modport  Direction  Payload
// poll     sink     in         button_released, time_ms[TIME_BITS-1:0]
// press    source   out        press_event[1:0] (none / short / long)
// APB      slave    in/out     debounce_ms @ 0x0, long_press_ms @ 0x4
//
// One poll per cycle while press.ready holds; a result is valid once its poll
// moves into the result register, and leaves at the next edge at the earliest.
// The press state advances as a poll moves into the result register.
// arst_n clears the state to released/disarmed and loads the register defaults.
// A stalled press channel holds the result register; once the poll register
// also fills, poll.ready drops until the result is taken.
module button_debounce_press_classifier #(
	parameter int TIME_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	bdpc_poll_if.sink                        poll,
	bdpc_event_if.source                     press,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [bdpc_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [bdpc_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [bdpc_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready
);
	import bdpc_pkg::*;

	cfg_t                 cfg;

	// Poll register
	logic                 valid_s1;
	logic                 released_s1;
	logic [TIME_BITS-1:0] time_s1;

	// Result register
	logic                 out_valid_q;
	logic [EV_W-1:0]      event_q;

	logic [EV_W-1:0]      event_d;
	logic                 out_free;
	logic                 advance;

	bdpc_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bdpc_classify #(
		.TIME_BITS (TIME_BITS)
	) u_classify (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (advance),
		.button_released (released_s1),
		.time_ms         (time_s1),
		.cfg             (cfg),
		.press_event     (event_d)
	);

	// Result register takes a new value when empty or being drained
	assign out_free   = !out_valid_q || press.ready;
	assign advance    = valid_s1 && out_free;
	// Poll register refills whenever its content moves on or it is empty
	assign poll.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			released_s1 <= poll.button_released;
			time_s1     <= poll.time_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_q <= event_d;
		end
	end

	assign press.valid       = out_valid_q;
	assign press.press_event = event_q;

endmodule
